### design/servo_axis_pid_clamp_deadband_unit_assert.svh
// Assertion helpers for the servo axis unit.
`ifndef SERVO_AXIS_PID_CLAMP_DEADBAND_UNIT_ASSERT_SVH
`define SERVO_AXIS_PID_CLAMP_DEADBAND_UNIT_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define SPID_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("servo axis assertion failed");

// Next-cycle implication, disabled in reset.
`define SPID_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("servo axis assertion failed");

`endif

### design/spid_pkg.sv
package spid_pkg;

   localparam int OFFSET_BITS = 11;
   localparam int SUM_BITS    = 24;

   localparam int GAIN_BITS  = 16;
   localparam int LIM_BITS   = 7;
   localparam int TRIP_BITS  = 7;
   localparam int DB_BITS    = 10;
   localparam int DRIVE_BITS = 8;
   localparam int KIND_BITS  = 2;
   localparam int FRAC_BITS  = 12;

   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 16;

   // product and accumulator widths (gains carry an extra zero sign bit)
   localparam int DELTA_BITS = OFFSET_BITS + 1;
   localparam int PP_BITS    = OFFSET_BITS + GAIN_BITS + 1;
   localparam int PI_BITS    = SUM_BITS + GAIN_BITS + 1;
   localparam int PD_BITS    = DELTA_BITS + GAIN_BITS + 1;
   localparam int ACC_BITS   = ((PI_BITS > PD_BITS) ? PI_BITS : PD_BITS) + 2;
   localparam int DRV_BITS   = ACC_BITS - FRAC_BITS;
   localparam int CMP_BITS   = (OFFSET_BITS > DB_BITS) ? OFFSET_BITS : DB_BITS;

   localparam logic signed [OFFSET_BITS-1:0] OFF_MAX = {1'b0, {(OFFSET_BITS-1){1'b1}}};
   localparam logic signed [OFFSET_BITS-1:0] OFF_MIN = {1'b1, {(OFFSET_BITS-1){1'b0}}};
   localparam logic signed [SUM_BITS-1:0]    SUM_MAX = {1'b0, {(SUM_BITS-1){1'b1}}};
   localparam logic signed [SUM_BITS-1:0]    SUM_MIN = {1'b1, {(SUM_BITS-1){1'b0}}};

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] REG_GAIN_P   = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_GAIN_I   = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_GAIN_D   = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] REG_LIMIT    = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] REG_TRIP     = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] REG_DEADBAND = 3'd5;
   localparam logic [CSR_IDX_BITS-1:0] REG_INVERT   = 3'd6;

   // reset values
   localparam logic [GAIN_BITS-1:0] RST_GAIN_P   = 16'd3072;
   localparam logic [GAIN_BITS-1:0] RST_GAIN_I   = 16'd12;
   localparam logic [GAIN_BITS-1:0] RST_GAIN_D   = 16'd41;
   localparam logic [LIM_BITS-1:0]  RST_LIMIT    = 7'd27;
   localparam logic [TRIP_BITS-1:0] RST_TRIP     = 7'd6;
   localparam logic [DB_BITS-1:0]   RST_DEADBAND = 10'd10;

   // clamp kinds
   localparam logic [KIND_BITS-1:0] KIND_NONE = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_HIGH = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_LOW  = 2'd2;
   localparam logic [KIND_BITS-1:0] KIND_DEAD = 2'd3;

   typedef struct packed {
      logic [GAIN_BITS-1:0] gain_p;
      logic [GAIN_BITS-1:0] gain_i;
      logic [GAIN_BITS-1:0] gain_d;
      logic [LIM_BITS-1:0]  drive_limit;
      logic [TRIP_BITS-1:0] low_trip_offset;
      logic [DB_BITS-1:0]   dead_band;
      logic                 invert_error;
   } spid_cfg_type;

   typedef struct packed {
      logic signed [DRIVE_BITS-1:0] drive;
      logic [KIND_BITS-1:0]         clamp_kind;
   } spid_result_type;

endpackage

### design/spid_if.sv
interface spid_req_if;
   import spid_pkg::*;
   logic                          valid;
   logic                          ready;
   logic signed [OFFSET_BITS-1:0] target_offset;
   modport source (output valid, output target_offset, input ready);
   modport sink (input valid, input target_offset, output ready);
endinterface

interface spid_rsp_if;
   import spid_pkg::*;
   logic                         valid;
   logic                         ready;
   logic signed [DRIVE_BITS-1:0] drive;
   logic [KIND_BITS-1:0]         clamp_kind;
   modport source (output valid, output drive, output clamp_kind, input ready);
   modport sink (input valid, input drive, input clamp_kind, output ready);
endinterface

interface spid_csr_if;
   import spid_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [CSR_IDX_BITS-1:0]  index;
   logic [CSR_DATA_BITS-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

### design/spid_clamp.sv
module spid_clamp (
   input  logic signed [spid_pkg::ACC_BITS-1:0]    acc,
   input  logic [spid_pkg::OFFSET_BITS-1:0]        mag,
   input  spid_pkg::spid_cfg_type                  cfg,
   output spid_pkg::spid_result_type               result
);
   import spid_pkg::*;

   logic signed [DRV_BITS-1:0]   drv;
   logic                         round_up;
   logic signed [DRV_BITS-1:0]   lim_ext;
   logic signed [DRIVE_BITS-1:0] low_thr;
   logic signed [DRIVE_BITS-1:0] lim_s;
   logic                         in_band;

   // truncate toward zero: floor, then bump negatives with a fraction
   assign round_up = acc[ACC_BITS-1] && (acc[FRAC_BITS-1:0] != '0);
   assign drv      = acc[ACC_BITS-1:FRAC_BITS] + DRV_BITS'(round_up);

   assign lim_s   = $signed({1'b0, cfg.drive_limit});
   assign lim_ext = DRV_BITS'(lim_s);
   assign low_thr = $signed({1'b0, cfg.low_trip_offset}) - lim_s;
   assign in_band = CMP_BITS'(mag) <= CMP_BITS'(cfg.dead_band);

   always_comb begin
      if (drv >= lim_ext) begin
         result.drive      = lim_s;
         result.clamp_kind = KIND_HIGH;
      end else if (drv <= DRV_BITS'(low_thr)) begin
         result.drive      = -lim_s;
         result.clamp_kind = KIND_LOW;
      end else if (in_band) begin
         result.drive      = '0;
         result.clamp_kind = KIND_DEAD;
      end else begin
         // strictly inside +-limit here, so the low byte is exact
         result.drive      = drv[DRIVE_BITS-1:0];
         result.clamp_kind = KIND_NONE;
      end
   end

endmodule

### design/servo_axis_pid_clamp_deadband_unit.sv
// Servo axis PID controller with output clamp and deadband.
// req_chan carries one signed target offset per request; rsp_chan returns
// one drive value and clamp kind for each, in order. csr_chan writes the
// gain, limit, trip, deadband and invert registers by index; it is always
// ready and unknown indexes are ignored. Write it only while idle.
// An accepted request passes through the input register and then the
// result register, from which its result is offered to rsp_chan.
// Throughput: one request per cycle while the receiver does not stall.
// The error and saturating sum are formed as the request is taken into the
// input register; the three gain products, their sum, the truncation and
// the clamp settle combinationally into the result register.
// The error sum and last error update as each request is accepted.
// Reset (synchronous, active high) restores register defaults, clears
// the error sum and last error, and empties both registers.
// When the receiver stalls, the result waits in the result register;
// req_chan.ready drops only once the input and result registers both hold
// a request.
`include "servo_axis_pid_clamp_deadband_unit_assert.svh"

module servo_axis_pid_clamp_deadband_unit (
   input  logic       clock,
   input  logic       reset,
   spid_req_if.sink   req_chan,
   spid_rsp_if.source rsp_chan,
   spid_csr_if.sink   csr_chan
);
   import spid_pkg::*;

   spid_cfg_type cfg_ff;

   logic signed [SUM_BITS-1:0]    error_sum_ff, error_sum_in;
   logic signed [OFFSET_BITS-1:0] last_error_ff;

   // input register: error terms
   logic                          v1_ff;
   logic signed [OFFSET_BITS-1:0] s1_err_ff, s1_err_in;
   logic signed [SUM_BITS-1:0]    s1_sum_ff;
   logic signed [DELTA_BITS-1:0]  s1_delta_ff, s1_delta_in;
   logic [OFFSET_BITS-1:0]        s1_mag_ff, s1_mag_in;

   // products
   logic signed [PP_BITS-1:0] prod_p;
   logic signed [PI_BITS-1:0] prod_i;
   logic signed [PD_BITS-1:0] prod_d;

   // result register
   logic            v2_ff;
   spid_result_type rsp_ff, rsp_in;

   logic signed [ACC_BITS-1:0]    acc;
   logic signed [SUM_BITS:0]      sum_wide;
   logic signed [OFFSET_BITS-1:0] offset;
   logic                          ld1, ld2, accept;

   assign ld2    = !v2_ff || rsp_chan.ready;
   assign ld1    = !v1_ff || ld2;
   assign accept = req_chan.valid && ld1;

   assign req_chan.ready      = ld1;
   assign rsp_chan.valid      = v2_ff;
   assign rsp_chan.drive      = rsp_ff.drive;
   assign rsp_chan.clamp_kind = rsp_ff.clamp_kind;
   assign csr_chan.ready      = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_p          <= RST_GAIN_P;
         cfg_ff.gain_i          <= RST_GAIN_I;
         cfg_ff.gain_d          <= RST_GAIN_D;
         cfg_ff.drive_limit     <= RST_LIMIT;
         cfg_ff.low_trip_offset <= RST_TRIP;
         cfg_ff.dead_band       <= RST_DEADBAND;
         cfg_ff.invert_error    <= 1'b0;
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            REG_GAIN_P:   cfg_ff.gain_p          <= csr_chan.data[GAIN_BITS-1:0];
            REG_GAIN_I:   cfg_ff.gain_i          <= csr_chan.data[GAIN_BITS-1:0];
            REG_GAIN_D:   cfg_ff.gain_d          <= csr_chan.data[GAIN_BITS-1:0];
            REG_LIMIT:    cfg_ff.drive_limit     <= csr_chan.data[LIM_BITS-1:0];
            REG_TRIP:     cfg_ff.low_trip_offset <= csr_chan.data[TRIP_BITS-1:0];
            REG_DEADBAND: cfg_ff.dead_band       <= csr_chan.data[DB_BITS-1:0];
            REG_INVERT:   cfg_ff.invert_error    <= csr_chan.data[0];
            default: ;
         endcase
      end
   end

   // error, saturating sum, error difference and offset magnitude from the incoming request
   always_comb begin
      offset = req_chan.target_offset;
      if (cfg_ff.invert_error) begin
         s1_err_in = (offset == OFF_MIN) ? OFF_MAX : -offset;
      end else begin
         s1_err_in = offset;
      end
      sum_wide = (SUM_BITS+1)'(error_sum_ff) + (SUM_BITS+1)'(s1_err_in);
      if (sum_wide[SUM_BITS] != sum_wide[SUM_BITS-1]) begin
         error_sum_in = sum_wide[SUM_BITS] ? SUM_MIN : SUM_MAX;
      end else begin
         error_sum_in = sum_wide[SUM_BITS-1:0];
      end
      s1_delta_in = DELTA_BITS'(s1_err_in) - DELTA_BITS'(last_error_ff);
      s1_mag_in   = offset[OFFSET_BITS-1] ? (~offset + 1'b1) : offset;
   end

   assign prod_p = $signed({1'b0, cfg_ff.gain_p}) * s1_err_ff;
   assign prod_i = $signed({1'b0, cfg_ff.gain_i}) * s1_sum_ff;
   assign prod_d = $signed({1'b0, cfg_ff.gain_d}) * s1_delta_ff;

   assign acc = ACC_BITS'(prod_p) + ACC_BITS'(prod_i) + ACC_BITS'(prod_d);

   spid_clamp u_clamp (
      .acc    (acc),
      .mag    (s1_mag_ff),
      .cfg    (cfg_ff),
      .result (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         error_sum_ff  <= '0;
         last_error_ff <= '0;
         v1_ff         <= 1'b0;
         v2_ff         <= 1'b0;
      end else begin
         if (accept) begin
            error_sum_ff  <= error_sum_in;
            last_error_ff <= s1_err_in;
         end
         if (ld1) begin
            v1_ff <= req_chan.valid;
         end
         if (ld2) begin
            v2_ff <= v1_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_err_ff   <= s1_err_in;
         s1_sum_ff   <= error_sum_in;
         s1_delta_ff <= s1_delta_in;
         s1_mag_ff   <= s1_mag_in;
      end
      if (ld2 && v1_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   `SPID_ASSERT_IMP(a_dead_zero, clock, reset,
      v2_ff && rsp_ff.clamp_kind == KIND_DEAD, rsp_ff.drive == '0)
   `SPID_ASSERT_IMP(a_high_nonneg, clock, reset,
      v2_ff && rsp_ff.clamp_kind == KIND_HIGH, !rsp_ff.drive[DRIVE_BITS-1])
   `SPID_ASSERT_IMP(a_low_nonpos, clock, reset,
      v2_ff && rsp_ff.clamp_kind == KIND_LOW, rsp_ff.drive[DRIVE_BITS-1] || rsp_ff.drive == '0)
   `SPID_ASSERT_IMP(a_full_stall, clock, reset,
      v1_ff && v2_ff && !rsp_chan.ready, !req_chan.ready)
   `SPID_ASSERT_NXT(a_stage1_held, clock, reset, v1_ff && !ld2, v1_ff)

endmodule
